[rtl/core/sla_pkg.sv]
// Shared widths, codes and controller/datapath interface types for the slot allocator.
package sla_pkg;

  localparam int SLOTS       = 256;
  localparam int IDX_W       = $clog2(SLOTS);
  localparam int CNT_W       = $clog2(SLOTS + 1);
  localparam int HANDLE_W    = 32;
  localparam int OP_W        = 2;
  localparam int STATUS_W    = 4;

  // Input beat: tdata = handle, merge_duplicates, slot_index; tuser = opcode
  localparam int S_PAYLOAD_W = HANDLE_W + 1 + IDX_W;
  localparam int S_TDATA_W   = ((S_PAYLOAD_W + 7) / 8) * 8;
  // Output beat: tdata = result_index, result_handle, slots_ever_used; tuser = status
  localparam int M_PAYLOAD_W = IDX_W + HANDLE_W + CNT_W;
  localparam int M_TDATA_W   = ((M_PAYLOAD_W + 7) / 8) * 8;

  typedef enum logic [OP_W-1:0] {
    OP_ALLOC  = 2'd0,
    OP_FREE   = 2'd1,
    OP_LOOKUP = 2'd2
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_NEW      = 4'd0,
    ST_REUSED   = 4'd1,
    ST_DUP      = 4'd2,
    ST_NULL     = 4'd3,
    ST_FULL     = 4'd4,
    ST_FREED    = 4'd5,
    ST_NOTFOUND = 4'd6,
    ST_HIT      = 4'd7,
    ST_EMPTY    = 4'd8
  } status_t;

  // State update carried out when a result is committed
  typedef enum logic [1:0] {
    ACT_NONE   = 2'd0,
    ACT_APPEND = 2'd1,
    ACT_REUSE  = 2'd2,
    ACT_FREE   = 2'd3
  } act_t;

  // Where result_index comes from
  typedef enum logic [2:0] {
    IDX_ZERO = 3'd0,
    IDX_HIT  = 3'd1,
    IDX_POP  = 3'd2,
    IDX_USED = 3'd3,
    IDX_SIDX = 3'd4
  } idx_src_t;

  typedef struct packed {
    status_t  status;
    act_t     act;
    idx_src_t idx_src;
    logic     take_handle;
  } commit_t;

  typedef struct packed {
    logic    capture;
    logic    scan_start;
    logic    scan_run;
    logic    look_rd;
    logic    pop_rd;
    logic    commit;
    commit_t cmt;
  } dp_cmd_t;

  typedef struct packed {
    op_t  op;
    logic h_zero;
    logic merge;
    logic stack_empty;
    logic full;
    logic look_in_range;
    logic hit;
    logic exhausted;
    logic rd_nonzero;
    logic out_free;
  } dp_stat_t;

endpackage

[rtl/core/sla_ctrl.sv]
// Sequencing state machine for the slot allocator: decode, scan, pop, lookup, commit.
module sla_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  sla_pkg::dp_stat_t stat,
  output sla_pkg::dp_cmd_t  cmd
);
  import sla_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_SCAN,
    S_POP,
    S_LOOK,
    S_COMMIT
  } state_t;

  state_t  state, state_next;
  commit_t cmt, cmt_next;
  logic    want_place;

  always_comb begin
    state_next = state;
    cmt_next   = cmt;
    want_place = 1'b0;
    cmd        = '0;
    cmd.cmt    = cmt;
    s_tready   = (state == S_IDLE);

    unique case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          cmd.capture = 1'b1;
          state_next  = S_DECODE;
        end
      end
      S_DECODE: begin
        priority case (stat.op)
          OP_ALLOC: begin
            if (stat.h_zero) begin
              cmt_next   = '{status: ST_NULL, act: ACT_NONE, idx_src: IDX_ZERO,
                             take_handle: 1'b0};
              state_next = S_COMMIT;
            end else if (stat.merge) begin
              cmd.scan_start = 1'b1;
              state_next     = S_SCAN;
            end else begin
              want_place = 1'b1;
            end
          end
          OP_FREE: begin
            if (stat.h_zero) begin
              cmt_next   = '{status: ST_NOTFOUND, act: ACT_NONE, idx_src: IDX_ZERO,
                             take_handle: 1'b0};
              state_next = S_COMMIT;
            end else begin
              cmd.scan_start = 1'b1;
              state_next     = S_SCAN;
            end
          end
          OP_LOOKUP: begin
            if (stat.look_in_range) begin
              cmd.look_rd = 1'b1;
              state_next  = S_LOOK;
            end else begin
              cmt_next   = '{status: ST_EMPTY, act: ACT_NONE, idx_src: IDX_ZERO,
                             take_handle: 1'b0};
              state_next = S_COMMIT;
            end
          end
          default: begin
            cmt_next   = '{status: ST_EMPTY, act: ACT_NONE, idx_src: IDX_ZERO,
                           take_handle: 1'b0};
            state_next = S_COMMIT;
          end
        endcase
      end
      S_SCAN: begin
        cmd.scan_run = 1'b1;
        if (stat.hit) begin
          if (stat.op == OP_FREE) begin
            cmt_next = '{status: ST_FREED, act: ACT_FREE, idx_src: IDX_HIT,
                         take_handle: 1'b0};
          end else begin
            cmt_next = '{status: ST_DUP, act: ACT_NONE, idx_src: IDX_HIT,
                         take_handle: 1'b0};
          end
          state_next = S_COMMIT;
        end else if (stat.exhausted) begin
          if (stat.op == OP_FREE) begin
            cmt_next   = '{status: ST_NOTFOUND, act: ACT_NONE, idx_src: IDX_ZERO,
                           take_handle: 1'b0};
            state_next = S_COMMIT;
          end else begin
            want_place = 1'b1;
          end
        end
      end
      S_POP: begin
        cmt_next   = '{status: ST_REUSED, act: ACT_REUSE, idx_src: IDX_POP,
                       take_handle: 1'b0};
        state_next = S_COMMIT;
      end
      S_LOOK: begin
        if (stat.rd_nonzero) begin
          cmt_next = '{status: ST_HIT, act: ACT_NONE, idx_src: IDX_SIDX,
                       take_handle: 1'b1};
        end else begin
          cmt_next = '{status: ST_EMPTY, act: ACT_NONE, idx_src: IDX_ZERO,
                       take_handle: 1'b0};
        end
        state_next = S_COMMIT;
      end
      S_COMMIT: begin
        if (stat.out_free) begin
          cmd.commit = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase

    // Place a new allocation: pop the free stack, else append, else full
    if (want_place) begin
      if (!stat.stack_empty) begin
        cmd.pop_rd = 1'b1;
        state_next = S_POP;
      end else if (!stat.full) begin
        cmt_next   = '{status: ST_NEW, act: ACT_APPEND, idx_src: IDX_USED,
                       take_handle: 1'b0};
        state_next = S_COMMIT;
      end else begin
        cmt_next   = '{status: ST_FULL, act: ACT_NONE, idx_src: IDX_ZERO,
                       take_handle: 1'b0};
        state_next = S_COMMIT;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cmt   <= '0;
    end else begin
      state <= state_next;
      cmt   <= cmt_next;
    end
  end

endmodule

[rtl/core/sla_datapath.sv]
// Slot table, free stack, counters, scan pipeline and output register of the slot allocator.
module sla_datapath (
  input  logic                              clk,
  input  logic                              rst,
  input  sla_pkg::dp_cmd_t                  cmd,
  output sla_pkg::dp_stat_t                 stat,
  input  logic [sla_pkg::S_TDATA_W-1:0]     s_tdata,
  input  logic [sla_pkg::OP_W-1:0]          s_tuser,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [sla_pkg::M_TDATA_W-1:0]     m_tdata,
  output logic [sla_pkg::STATUS_W-1:0]      m_tuser
);
  import sla_pkg::*;

  // Latched request
  logic [HANDLE_W-1:0] h_q;
  op_t                 op_q;
  logic                merge_q;
  logic [IDX_W-1:0]    sidx_q;

  logic [CNT_W-1:0]    used_count;
  logic [CNT_W-1:0]    free_top;
  logic [CNT_W-1:0]    scan_idx;

  logic [HANDLE_W-1:0] slot_mem  [SLOTS];
  logic [IDX_W-1:0]    stack_mem [SLOTS];
  logic [HANDLE_W-1:0] slot_rd;
  logic [IDX_W-1:0]    stack_rd;

  logic                rd_vld;
  logic [IDX_W-1:0]    rd_idx;
  logic                scan_more;
  logic                issue;
  logic                hit;
  logic                slot_re;
  logic [IDX_W-1:0]    slot_raddr;
  logic                slot_we;
  logic [IDX_W-1:0]    slot_waddr;
  logic [HANDLE_W-1:0] slot_wdata;
  logic                push;
  logic                pop;
  logic [IDX_W-1:0]    top_m1;

  logic [IDX_W-1:0]    res_idx;
  logic [CNT_W-1:0]    res_used;

  status_t             out_status;
  logic [IDX_W-1:0]    out_idx;
  logic [HANDLE_W-1:0] out_handle;
  logic [CNT_W-1:0]    out_used;

  assign scan_more  = (scan_idx < used_count);
  assign hit        = rd_vld && (slot_rd == h_q);
  assign issue      = cmd.scan_run && !hit && scan_more;
  assign slot_re    = issue || cmd.look_rd;
  assign slot_raddr = cmd.look_rd ? sidx_q : scan_idx[IDX_W-1:0];
  assign top_m1     = IDX_W'(free_top - CNT_W'(1));

  assign push = cmd.commit && (cmd.cmt.act == ACT_FREE) && (free_top < CNT_W'(SLOTS));
  assign pop  = cmd.commit && (cmd.cmt.act == ACT_REUSE);

  always_comb begin
    slot_we    = cmd.commit && (cmd.cmt.act != ACT_NONE);
    slot_waddr = used_count[IDX_W-1:0];
    slot_wdata = h_q;
    unique case (cmd.cmt.act)
      ACT_APPEND: slot_waddr = used_count[IDX_W-1:0];
      ACT_REUSE:  slot_waddr = stack_rd;
      ACT_FREE: begin
        slot_waddr = rd_idx;
        slot_wdata = '0;
      end
      ACT_NONE:   slot_waddr = used_count[IDX_W-1:0];
    endcase
  end

  always_comb begin
    unique case (cmd.cmt.idx_src)
      IDX_ZERO: res_idx = '0;
      IDX_HIT:  res_idx = rd_idx;
      IDX_POP:  res_idx = stack_rd;
      IDX_USED: res_idx = used_count[IDX_W-1:0];
      IDX_SIDX: res_idx = sidx_q;
      default:  res_idx = '0;
    endcase
  end

  assign res_used = used_count + CNT_W'(cmd.cmt.act == ACT_APPEND);

  // Memories
  always_ff @(posedge clk) begin
    if (slot_we) begin
      slot_mem[slot_waddr] <= slot_wdata;
    end
    if (slot_re) begin
      slot_rd <= slot_mem[slot_raddr];
    end
    if (push) begin
      stack_mem[free_top[IDX_W-1:0]] <= rd_idx;
    end
    if (cmd.pop_rd) begin
      stack_rd <= stack_mem[top_m1];
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      used_count <= '0;
      free_top   <= '0;
      scan_idx   <= '0;
      rd_vld     <= 1'b0;
      m_tvalid   <= 1'b0;
    end else begin
      rd_vld <= issue;
      if (cmd.scan_start) begin
        scan_idx <= '0;
      end else if (issue) begin
        scan_idx <= scan_idx + CNT_W'(1);
      end
      if (cmd.commit && (cmd.cmt.act == ACT_APPEND)) begin
        used_count <= used_count + CNT_W'(1);
      end
      if (push) begin
        free_top <= free_top + CNT_W'(1);
      end else if (pop) begin
        free_top <= free_top - CNT_W'(1);
      end
      if (cmd.commit) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      h_q     <= s_tdata[HANDLE_W-1:0];
      merge_q <= s_tdata[HANDLE_W];
      sidx_q  <= s_tdata[HANDLE_W+1 +: IDX_W];
      op_q    <= op_t'(s_tuser);
    end
    if (issue) begin
      rd_idx <= scan_idx[IDX_W-1:0];
    end
    if (cmd.commit) begin
      out_status <= cmd.cmt.status;
      out_idx    <= res_idx;
      out_handle <= cmd.cmt.take_handle ? slot_rd : '0;
      out_used   <= res_used;
    end
  end

  assign m_tdata = M_TDATA_W'({out_used, out_handle, out_idx});
  assign m_tuser = out_status;

  always_comb begin
    stat.op            = op_q;
    stat.h_zero        = (h_q == '0);
    stat.merge         = merge_q;
    stat.stack_empty   = (free_top == '0);
    stat.full          = (used_count == CNT_W'(SLOTS));
    stat.look_in_range = (CNT_W'(sidx_q) < used_count);
    stat.hit           = hit;
    stat.exhausted     = !rd_vld && !scan_more;
    stat.rd_nonzero    = (slot_rd != '0);
    stat.out_free      = !m_tvalid || m_tready;
  end

endmodule

[rtl/core/slot_allocator_lifo_free_list_top.sv]
// Top level of the slot allocator: stream ports, controller, datapath and assertions.
//
// Slot allocator with a LIFO free list. A table of 256 slots maps nonzero 32-bit handles
// to slot indices; handle 0 means null. Each input beat carries one request (opcode in
// tuser: allocate, free by handle, look up by index) and yields exactly one result beat
// (status in tuser). Allocate rejects a null handle, optionally returns the slot that
// already holds the handle, otherwise reuses the most recently freed slot, appends a new
// slot or reports full. Free clears the first slot holding the handle and stacks its
// index; a null handle is ignored. Requests are handled one at a time. A request
// goes from decode straight to commit for the null, unknown, append, full and
// out-of-range lookup cases, and through one registered read first for a reuse or an
// in-range lookup. A merging allocate or a free scans the appended slots one per cycle
// through the single read port of the handle table, so its result waits on a scan
// that grows with slots_ever_used. The next beat is taken the cycle after the result is
// committed; a result beat that is not taken holds the commit, and with it the input. A
// finished result waits in the output register while the next request is accepted. Both
// tables need no clearing after reset: only slots below the append count and stack
// entries below the stack top are ever read.
module slot_allocator_lifo_free_list_top (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // handle [31:0], merge_duplicates [32], slot_index [40:33], zero fill above
  input  logic [sla_pkg::S_TDATA_W-1:0]     s_axis_tdata,
  // opcode [1:0]
  input  logic [sla_pkg::OP_W-1:0]          s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // result_index [7:0], result_handle [39:8], slots_ever_used [48:40], zero fill above
  output logic [sla_pkg::M_TDATA_W-1:0]     m_axis_tdata,
  // status [3:0]
  output logic [sla_pkg::STATUS_W-1:0]      m_axis_tuser
);
  import sla_pkg::*;

  localparam int OUT_HANDLE_LO = IDX_W;
  localparam int OUT_USED_LO   = IDX_W + HANDLE_W;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // Sequence each request through decode, scan or read, and commit
  sla_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_axis_tvalid),
    .s_tready (s_axis_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Hold the tables and counters, and drive the result beat
  sla_datapath u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .stat     (stat),
    .s_tdata  (s_axis_tdata),
    .s_tuser  (s_axis_tuser),
    .m_tvalid (m_axis_tvalid),
    .m_tready (m_axis_tready),
    .m_tdata  (m_axis_tdata),
    .m_tuser  (m_axis_tuser)
  );

  // A handle is reported only on a lookup hit, and a hit never reports a null handle
  a_handle_only_on_hit: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |->
      ((m_axis_tuser == ST_HIT) == (m_axis_tdata[OUT_USED_LO-1:OUT_HANDLE_LO] != '0)))
    else $error("result handle does not match hit status");

  // Outcomes without a slot report index zero
  a_zero_index: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tuser == ST_NULL || m_axis_tuser == ST_FULL ||
                      m_axis_tuser == ST_NOTFOUND || m_axis_tuser == ST_EMPTY)
      |-> (m_axis_tdata[IDX_W-1:0] == '0))
    else $error("nonzero index on a slotless outcome");

  // The append count never passes the table size
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[OUT_USED_LO +: CNT_W] <= CNT_W'(SLOTS)))
    else $error("slots_ever_used beyond table size");

  // A commit only happens when the output register can take the beat
  a_commit_room: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> (!m_axis_tvalid || m_axis_tready))
    else $error("result committed over an untaken beat");

endmodule
